/* rtl/core/cedec_pkg.sv */
package cedec_pkg;

  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned CFG_IDX_W  = 2;
  // wide enough for any sector end offset and any image size in range
  localparam int unsigned OFF_W      = 22;

  localparam int unsigned SECT_BYTES       = 256;
  localparam int unsigned SECT_SHIFT       = 8;
  localparam int unsigned SECTS_PER_TRACK  = 10;
  localparam int unsigned TRACK_BYTES      = SECT_BYTES * SECTS_PER_TRACK;
  localparam int unsigned TRACK_PAIR_BYTES = TRACK_BYTES * 2;
  localparam logic [4:0]  LAST_ENTRY       = 5'd31;
  localparam logic [6:0]  CHAR_SPACE       = 7'h20;

  // x/10 as (x * 52429) >> 19, exact for x below 43699
  localparam logic [15:0] DIV10_RECIP = 16'd52429;
  localparam int unsigned DIV10_SHIFT = 19;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_CAT     = 3'd1,
    ST_PAST_SECTOR = 3'd2,
    ST_TOO_LONG    = 3'd3,
    ST_OUTSIDE     = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INTERLEAVED = 2'd0,
    REG_DISC_BYTES  = 2'd1,
    REG_READ_LIMIT  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic             interleaved;
    logic [OFF_W-1:0] disc_bytes;
    logic [OFF_W-1:0] read_limit;
  } cfg_state_t;

  typedef struct packed {
    logic        side;
    status_t     status;
    logic        locked;
    logic [6:0]  directory;
    logic [55:0] name_chars;
    logic [2:0]  name_length;
    logic [17:0] load_addr;
    logic [17:0] exec_addr;
    logic [17:0] file_length;
    logic [9:0]  first_sector;
    logic [10:0] last_sector;
  } entry_t;

endpackage

/* rtl/core/cedec_ifs.sv */
interface cedec_entry_if;
  logic        valid;
  logic        ready;
  logic        side;
  logic [4:0]  entry_index;
  logic [63:0] name_bytes;
  logic [63:0] info_bytes;

  modport source (output valid, side, entry_index, name_bytes, info_bytes, input ready);
  modport sink   (input valid, side, entry_index, name_bytes, info_bytes, output ready);
endinterface

interface cedec_result_if;
  logic        valid;
  logic        ready;
  logic        locked;
  logic [6:0]  directory;
  logic [55:0] name_chars;
  logic [2:0]  name_length;
  logic [17:0] load_addr;
  logic [17:0] exec_addr;
  logic [17:0] file_length;
  logic [9:0]  first_sector;
  logic [2:0]  status;

  modport source (output valid, locked, directory, name_chars, name_length, load_addr,
                  exec_addr, file_length, first_sector, status, input ready);
  modport sink   (input valid, locked, directory, name_chars, name_length, load_addr,
                  exec_addr, file_length, first_sector, status, output ready);
endinterface

interface cedec_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [cedec_pkg::CFG_IDX_W-1:0]  index;
  logic [cedec_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/cedec_cfg_regs.sv */
module cedec_cfg_regs #(
  parameter int unsigned MAX_IMAGE_BYTES = 524288
) (
  input  logic                  clk,
  input  logic                  rst,
  cedec_cfg_if.sink             cfg,
  output cedec_pkg::cfg_state_t cfg_st
);
  localparam int unsigned IMG_W = $clog2(MAX_IMAGE_BYTES + 1);
  localparam int unsigned LIM_W = (IMG_W > cedec_pkg::CFG_DATA_W) ? IMG_W
                                                                    : cedec_pkg::CFG_DATA_W;
  localparam logic [cedec_pkg::OFF_W-1:0] MAX_BYTES = cedec_pkg::OFF_W'(MAX_IMAGE_BYTES);

  logic             interleaved;
  logic [IMG_W-1:0] disc_bytes;
  logic [LIM_W-1:0] read_limit;
  logic [cedec_pkg::OFF_W-1:0] wdata;

  assign cfg.ready = 1'b1;
  assign wdata = cedec_pkg::OFF_W'(cfg.data);

  always_ff @(posedge clk) begin
    if (rst) begin
      interleaved <= 1'b0;
      disc_bytes  <= '0;
      read_limit  <= LIM_W'(MAX_IMAGE_BYTES);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        cedec_pkg::REG_INTERLEAVED: interleaved <= cfg.data[0];
        cedec_pkg::REG_DISC_BYTES: begin
          // saturate at the largest supported image
          if (wdata > MAX_BYTES) disc_bytes <= IMG_W'(MAX_IMAGE_BYTES);
          else                   disc_bytes <= IMG_W'(wdata);
        end
        cedec_pkg::REG_READ_LIMIT: read_limit <= LIM_W'(cfg.data);
        default: ;
      endcase
    end
  end

  assign cfg_st.interleaved = interleaved;
  assign cfg_st.disc_bytes  = cedec_pkg::OFF_W'(disc_bytes);
  assign cfg_st.read_limit  = cedec_pkg::OFF_W'(read_limit);
endmodule

/* rtl/core/cedec_decode.sv */
module cedec_decode (
  input  logic                  clk,
  input  logic                  rst,
  cedec_entry_if.sink           entry,
  input  cedec_pkg::cfg_state_t cfg_st,
  output logic                  dec_valid,
  input  logic                  dec_ready,
  output cedec_pkg::entry_t     dec
);
  // both catalogue sectors lie in the image when sector 1 does
  localparam logic [cedec_pkg::OFF_W-1:0] CAT_END =
    cedec_pkg::OFF_W'(2 * cedec_pkg::SECT_BYTES);
  localparam logic [cedec_pkg::OFF_W-1:0] CAT_END_SIDE1 =
    cedec_pkg::OFF_W'(cedec_pkg::TRACK_BYTES + 2 * cedec_pkg::SECT_BYTES);

  cedec_pkg::entry_t dec_next;
  logic              advance;

  assign advance     = !dec_valid || dec_ready;
  assign entry.ready = advance;

  always_comb begin
    logic [cedec_pkg::OFF_W-1:0] cat_end;
    logic [6:0]  ch;
    logic        stop;
    logic [17:0] len;
    logic [9:0]  start;
    logic [63:0] nb;
    logic [63:0] ib;

    nb = entry.name_bytes;
    ib = entry.info_bytes;
    ch = '0;
    stop = 1'b0;
    len = '0;
    start = '0;
    cat_end = (entry.side && cfg_st.interleaved) ? CAT_END_SIDE1 : CAT_END;
    dec_next = '0;
    dec_next.side = entry.side;

    priority if ((entry.side && !cfg_st.interleaved) || cat_end > cfg_st.disc_bytes) begin
      dec_next.status = cedec_pkg::ST_BAD_CAT;
    end else if (entry.entry_index == cedec_pkg::LAST_ENTRY) begin
      dec_next.status = cedec_pkg::ST_PAST_SECTOR;
    end else begin
      dec_next.status    = cedec_pkg::ST_OK;
      dec_next.locked    = nb[63];
      dec_next.directory = nb[62:56];
      stop = 1'b0;
      for (int n = 0; n < 7; n++) begin
        ch = nb[8*n +: 7];
        // name ends at the first zero or space
        if (stop || ch == 7'd0 || ch == cedec_pkg::CHAR_SPACE) begin
          stop = 1'b1;
        end else begin
          dec_next.name_chars[7*n +: 7] = ch;
          dec_next.name_length = dec_next.name_length + 3'd1;
        end
      end
      len   = {ib[53:52], ib[47:32]};
      start = {ib[49:48], ib[63:56]};
      dec_next.load_addr    = {ib[51:50], ib[15:0]};
      dec_next.exec_addr    = {ib[55:54], ib[31:16]};
      dec_next.file_length  = len;
      dec_next.first_sector = start;
      dec_next.last_sector  = 11'(start) + 11'((len - 18'd1) >> cedec_pkg::SECT_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_valid <= 1'b0;
    end else if (advance) begin
      dec_valid <= entry.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && entry.valid) begin
      dec <= dec_next;
    end
  end
endmodule

/* rtl/core/cedec_span.sv */
module cedec_span (
  input  logic                  clk,
  input  logic                  rst,
  input  cedec_pkg::cfg_state_t cfg_st,
  input  logic                  dec_valid,
  output logic                  dec_ready,
  input  cedec_pkg::entry_t     dec,
  cedec_result_if.source        result
);
  localparam int unsigned PROD_W = 11 + 16;
  localparam logic [cedec_pkg::OFF_W-1:0] SECT_END = cedec_pkg::OFF_W'(cedec_pkg::SECT_BYTES);
  localparam logic [cedec_pkg::OFF_W-1:0] PAIR = cedec_pkg::OFF_W'(cedec_pkg::TRACK_PAIR_BYTES);
  localparam logic [cedec_pkg::OFF_W-1:0] SIDE_OFF = cedec_pkg::OFF_W'(cedec_pkg::TRACK_BYTES);

  // sector end offset, from the track number when interleaved
  function automatic logic [cedec_pkg::OFF_W-1:0] sector_end(
    input logic [10:0] ls, input logic [7:0] trk, input logic sd, input logic ilv);
    logic [3:0]                  rem;
    logic [cedec_pkg::OFF_W-1:0] off;
    rem = 4'(ls - 11'(trk) * 11'd10);
    if (ilv) begin
      off = cedec_pkg::OFF_W'(trk) * PAIR + (sd ? SIDE_OFF : '0)
          + (cedec_pkg::OFF_W'(rem) << cedec_pkg::SECT_SHIFT);
    end else begin
      off = cedec_pkg::OFF_W'(ls) << cedec_pkg::SECT_SHIFT;
    end
    return off + SECT_END;
  endfunction

  logic              v2, v3, v4;
  logic              adv2, adv3, adv4;
  cedec_pkg::entry_t e2, e3, e4;
  cedec_pkg::entry_t e4_next;
  logic [7:0]        trk_start, trk_last;
  logic              too_long2, too_long3;
  logic [cedec_pkg::OFF_W-1:0] end_start, end_last;
  logic [PROD_W-1:0] prod_start, prod_last;
  cedec_pkg::status_t status4;

  assign adv4      = !v4 || result.ready;
  assign adv3      = !v3 || adv4;
  assign adv2      = !v2 || adv3;
  assign dec_ready = adv2;

  assign prod_start = PROD_W'(dec.first_sector) * PROD_W'(cedec_pkg::DIV10_RECIP);
  assign prod_last  = PROD_W'(dec.last_sector) * PROD_W'(cedec_pkg::DIV10_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (adv2) v2 <= dec_valid;
      if (adv3) v3 <= v2;
      if (adv4) v4 <= v3;
    end
  end

  // stage 2: track numbers and length limit
  always_ff @(posedge clk) begin
    if (adv2 && dec_valid) begin
      e2        <= dec;
      trk_start <= prod_start[cedec_pkg::DIV10_SHIFT +: 8];
      trk_last  <= prod_last[cedec_pkg::DIV10_SHIFT +: 8];
      too_long2 <= cedec_pkg::OFF_W'(dec.file_length) > cfg_st.read_limit;
    end
  end

  // stage 3: byte offsets of first and last sector
  always_ff @(posedge clk) begin
    if (adv3 && v2) begin
      e3        <= e2;
      too_long3 <= too_long2;
      end_start <= sector_end(11'(e2.first_sector), trk_start, e2.side, cfg_st.interleaved);
      end_last  <= sector_end(e2.last_sector, trk_last, e2.side, cfg_st.interleaved);
    end
  end

  // stage 4: final status
  always_comb begin
    status4 = e3.status;
    if (e3.status == cedec_pkg::ST_OK) begin
      priority if (too_long3) begin
        status4 = cedec_pkg::ST_TOO_LONG;
      end else if (e3.file_length != 18'd0 &&
                   (end_start > cfg_st.disc_bytes || end_last > cfg_st.disc_bytes)) begin
        status4 = cedec_pkg::ST_OUTSIDE;
      end else begin
        status4 = cedec_pkg::ST_OK;
      end
    end
  end

  always_comb begin
    e4_next        = e3;
    e4_next.status = status4;
  end

  always_ff @(posedge clk) begin
    if (adv4 && v3) begin
      e4 <= e4_next;
    end
  end

  assign result.valid        = v4;
  assign result.locked       = e4.locked;
  assign result.directory    = e4.directory;
  assign result.name_chars   = e4.name_chars;
  assign result.name_length  = e4.name_length;
  assign result.load_addr    = e4.load_addr;
  assign result.exec_addr    = e4.exec_addr;
  assign result.file_length  = e4.file_length;
  assign result.first_sector = e4.first_sector;
  assign result.status       = e4.status;
endmodule

/* rtl/core/catalogue_entry_decoder.sv */
// Catalogue entry decoder: takes one name-sector entry and its info-sector entry per
// transaction and returns the lock bit, directory, trimmed name, 18-bit load/exec/length
// fields, start sector and a status code checked against the image geometry set through
// the configuration channel. Fully pipelined: a new entry is accepted every cycle while the
// result side does not stall, and each result passes through the decode stage, the
// divide-by-ten track multiply, the sector offset adders and the final compare before it
// shows on the result port. Configuration writes take effect on the next cycle and are
// meant to be made while no entry is in flight.
module catalogue_entry_decoder #(
  parameter int unsigned MAX_IMAGE_BYTES = 524288
) (
  input  logic           clk,
  input  logic           rst,
  cedec_cfg_if.sink      cfg,
  cedec_entry_if.sink    entry,
  cedec_result_if.source result
);
  cedec_pkg::cfg_state_t cfg_st;
  cedec_pkg::entry_t     dec;
  logic                  dec_valid;
  logic                  dec_ready;

  cedec_cfg_regs #(
    .MAX_IMAGE_BYTES(MAX_IMAGE_BYTES)
  ) u_cfg_regs (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .cfg_st (cfg_st)
  );

  cedec_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .entry     (entry),
    .cfg_st    (cfg_st),
    .dec_valid (dec_valid),
    .dec_ready (dec_ready),
    .dec       (dec)
  );

  cedec_span u_span (
    .clk       (clk),
    .rst       (rst),
    .cfg_st    (cfg_st),
    .dec_valid (dec_valid),
    .dec_ready (dec_ready),
    .dec       (dec),
    .result    (result)
  );
endmodule

/* rtl/core/cedec_chk.sv */
module cedec_chk (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic        locked,
  input logic [6:0]  directory,
  input logic [55:0] name_chars,
  input logic [2:0]  name_length,
  input logic [17:0] load_addr,
  input logic [17:0] exec_addr,
  input logic [17:0] file_length,
  input logic [9:0]  first_sector,
  input logic [2:0]  status
);
  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(status) && $stable(name_chars)
                                && $stable(file_length) && $stable(first_sector))
    else $error("result changed while stalled");

  a_rejected_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && (status == cedec_pkg::ST_BAD_CAT || status == cedec_pkg::ST_PAST_SECTOR)
    |-> !locked && directory == 7'd0 && name_chars == 56'd0 && name_length == 3'd0
        && load_addr == 18'd0 && exec_addr == 18'd0 && file_length == 18'd0
        && first_sector == 10'd0)
    else $error("rejected entry carries decoded fields");

  a_outside_nonzero: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == cedec_pkg::ST_OUTSIDE |-> file_length != 18'd0)
    else $error("sector check flagged a zero-length file");

  a_empty_name: assert property (@(posedge clk) disable iff (rst)
    res_valid && name_length == 3'd0 |-> name_chars == 56'd0)
    else $error("empty name with characters");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> status <= cedec_pkg::ST_OUTSIDE)
    else $error("status code out of range");
endmodule

bind catalogue_entry_decoder cedec_chk u_chk (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (result.valid),
  .res_ready    (result.ready),
  .locked       (result.locked),
  .directory    (result.directory),
  .name_chars   (result.name_chars),
  .name_length  (result.name_length),
  .load_addr    (result.load_addr),
  .exec_addr    (result.exec_addr),
  .file_length  (result.file_length),
  .first_sector (result.first_sector),
  .status       (result.status)
);
